FILE: rtl/mbps_pkg.sv
`timescale 1ns / 1ps

package mbps_pkg;

  // bytes of signature held by the configuration registers
  localparam int unsigned SIG_REG_BYTES = 16;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned PAT_LEN_W     = 5;
  localparam int unsigned OUT_OFFSET_W  = 32;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_CARE_MASK      = 2'd2,
    CFG_PATTERN_LENGTH = 2'd3
  } cfg_index_e;

  // configuration register contents
  typedef struct packed {
    logic [CFG_DATA_W-1:0]    pattern_low;
    logic [CFG_DATA_W-1:0]    pattern_high;
    logic [SIG_REG_BYTES-1:0] care_mask;
    logic [PAT_LEN_W-1:0]     pattern_length;
  } cfg_t;

  // one byte leaving the input register
  typedef struct packed {
    logic       go;
    logic [7:0] data;
    logic       last;
  } step_t;

endpackage

FILE: rtl/mbps_cfg.sv
`timescale 1ns / 1ps

module mbps_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output mbps_pkg::cfg_t                    cfg_o
);
  import mbps_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_PATTERN_LOW:    cfg_d.pattern_low    = cfg_data_i;
        CFG_PATTERN_HIGH:   cfg_d.pattern_high   = cfg_data_i;
        CFG_CARE_MASK:      cfg_d.care_mask      = cfg_data_i[SIG_REG_BYTES-1:0];
        CFG_PATTERN_LENGTH: cfg_d.pattern_length = cfg_data_i[PAT_LEN_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/mbps_window.sv
`timescale 1ns / 1ps

module mbps_window #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32,
  parameter int unsigned WIN_DEPTH     = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mbps_pkg::step_t                step_i,
  output logic [WIN_DEPTH-1:0][7:0]      window_o,
  output logic [OFFSET_BITS-1:0]         count_o
);
  import mbps_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] window_q;
  logic [WIN_DEPTH-1:0][7:0] window_d;
  logic [OFFSET_BITS-1:0]    count_q;
  logic [OFFSET_BITS-1:0]    count_d;

  // shift the newest byte in at entry zero
  always_comb begin
    window_d = window_q;
    if (step_i.go) begin
      for (int i = WIN_DEPTH - 1; i > 0; i--) begin
        window_d[i] = window_q[i-1];
      end
      window_d[0] = step_i.data;
    end
  end

  // byte offset, restarts after the last byte, saturates at all ones
  always_comb begin
    count_d = count_q;
    if (step_i.go) begin
      if (step_i.last) begin
        count_d = '0;
      end else if (count_q != {OFFSET_BITS{1'b1}}) begin
        count_d = count_q + OFFSET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign window_o = window_q;
  assign count_o  = count_q;

endmodule

FILE: rtl/mbps_compare.sv
`timescale 1ns / 1ps

module mbps_compare #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32,
  parameter int unsigned WIN_DEPTH     = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1
) (
  input  mbps_pkg::cfg_t                          cfg_i,
  input  logic [7:0]                              cur_byte_i,
  input  logic [WIN_DEPTH-1:0][7:0]               window_i,
  input  logic [OFFSET_BITS-1:0]                  count_i,
  output logic                                    hit_o,
  output logic [mbps_pkg::OUT_OFFSET_W-1:0]       offset_o
);
  import mbps_pkg::*;

  localparam int unsigned LEN_W = $clog2(PATTERN_BYTES + 1);
  localparam int unsigned IDX_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

  logic [PATTERN_BYTES-1:0][7:0] seq;
  logic [PATTERN_BYTES-1:0][7:0] sig;
  logic [PATTERN_BYTES-1:0]      care;
  logic [2*CFG_DATA_W-1:0]       sig_all;
  logic [LEN_W-1:0]              len;
  logic [LEN_W-1:0]              len_m1;
  logic [OFFSET_BITS-1:0]        back_off;
  logic [OFFSET_BITS-1:0]        start;
  logic [PATTERN_BYTES-1:0]      byte_ok;
  logic                          enough;

  assign sig_all = {cfg_i.pattern_high, cfg_i.pattern_low};

  // newest byte first, then the window from most recent back
  assign seq[0] = cur_byte_i;
  for (genvar j = 1; j < PATTERN_BYTES; j++) begin : g_seq
    assign seq[j] = window_i[j-1];
  end

  // signature bytes past the register set are wildcards
  for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_sig
    if (k < SIG_REG_BYTES) begin : g_reg
      assign sig[k]  = sig_all[8*k +: 8];
      assign care[k] = cfg_i.care_mask[k];
    end else begin : g_none
      assign sig[k]  = '0;
      assign care[k] = 1'b0;
    end
  end

  // effective length, clamped to PATTERN_BYTES
  always_comb begin
    if (32'(cfg_i.pattern_length) > 32'(PATTERN_BYTES)) begin
      len = LEN_W'(PATTERN_BYTES);
    end else begin
      len = LEN_W'(cfg_i.pattern_length);
    end
    len_m1 = len - LEN_W'(1);
  end

  // per signature byte masked compare against its aligned buffer byte
  always_comb begin
    logic [IDX_W-1:0] back;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      back = IDX_W'(len_m1 - LEN_W'(k));
      if (LEN_W'(k) < len && care[k]) begin
        byte_ok[k] = (seq[back] == sig[k]);
      end else begin
        byte_ok[k] = 1'b1;
      end
    end
  end

  // start offset of the match, empty pattern reports the current offset
  always_comb begin
    if (len == '0) begin
      back_off = '0;
    end else begin
      back_off = OFFSET_BITS'(len_m1);
    end
    enough   = (count_i >= back_off);
    start    = count_i - back_off;
    hit_o    = (len == '0) || (enough && (&byte_ok));
    offset_o = OUT_OFFSET_W'(start);
  end

endmodule

FILE: rtl/masked_byte_pattern_scanner_unit.sv
// result: a matching byte's offset is registered when it leaves the input register
// throughput: one byte per cycle unless stalled; the input register and the result register
// are each one stage, so a stalled result holds back only a matching byte behind it
// reset: control, byte offset and configuration registers clear to zero;
// the byte window is not cleared and fills as the buffer arrives
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_unit #(
  parameter int unsigned PATTERN_BYTES = 16,
  parameter int unsigned OFFSET_BITS   = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                end_of_buffer_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mbps_pkg::OUT_OFFSET_W-1:0]   match_offset_o
);
  import mbps_pkg::*;

  localparam int unsigned WIN_DEPTH = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;

  cfg_t                      cfg;
  step_t                     step;
  logic [WIN_DEPTH-1:0][7:0] window;
  logic [OFFSET_BITS-1:0]    count;
  logic                      hit;
  logic [OUT_OFFSET_W-1:0]   offset;

  logic                      s1_valid_q;
  logic [7:0]                s1_byte_q;
  logic                      s1_last_q;
  logic                      out_valid_q;
  logic [OUT_OFFSET_W-1:0]   out_offset_q;
  logic                      out_free;
  logic                      s1_go;
  logic                      in_accept;

  mbps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: a byte with no result leaves even while the output waits
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_go      = s1_valid_q & (~hit | out_free);
  assign in_stall_o = s1_valid_q & ~s1_go;
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign step.go   = s1_go;
  assign step.data = s1_byte_q;
  assign step.last = s1_last_q;

  mbps_window #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS),
    .WIN_DEPTH     (WIN_DEPTH)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .window_o (window),
    .count_o  (count)
  );

  mbps_compare #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS),
    .WIN_DEPTH     (WIN_DEPTH)
  ) u_compare (
    .cfg_i      (cfg),
    .cur_byte_i (s1_byte_q),
    .window_i   (window),
    .count_i    (count),
    .hit_o      (hit),
    .offset_o   (offset)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= end_of_buffer_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && hit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && hit) begin
      out_offset_q <= offset;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign match_offset_o = out_offset_q;

  // stall only while the input register holds a byte it cannot pass on
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // a byte that matches is never dropped on its way to the result register
  a_hit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && hit) |=> (out_valid_o && match_offset_o == $past(offset)))
    else $error("matching byte left without a result");

  // the last byte of a buffer restarts the offset
  a_count_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> (count == '0))
    else $error("byte offset did not restart after the last byte");

  // a pending result is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !(s1_go && hit))
    else $error("new result while the held one is stalled");

endmodule
